FILE: hdl/pvt_pkg.sv
// Package for the plurality vote tally core: field widths, result codes and
// the word that the shared compare unit hands back to the sequencer.
// No dependencies.
package pvt_pkg;

    localparam int BALLOT_W   = 32;
    localparam int NODE_IDX_W = 5;
    localparam int COUNT_W    = 6;
    localparam int STATUS_W   = 2;

    // Packed widths of the stream words, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [COUNT_W-1:0] MIN_VOTES_RST = 6'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_AGREE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DISAGREE = 2'd2;

    // Input command codes.
    localparam logic CMD_VOTE  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Outcome of one pass of the shared compare unit.
    typedef struct packed {
        logic               match;
        logic               greater;
        logic               equal;
        logic [COUNT_W-1:0] eff_votes;
    } pvt_cmp_t;

endpackage

FILE: hdl/pvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pvt_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/pvt_cmp_unit.sv
// Shared compare unit: matches one candidate entry against the ballot, adds
// the new vote on a match and ranks the result against the running best.
// Depends on pvt_pkg.
module pvt_cmp_unit (
    input  logic [pvt_pkg::BALLOT_W-1:0] entry_value,
    input  logic [pvt_pkg::COUNT_W-1:0]  entry_votes,
    input  logic [pvt_pkg::BALLOT_W-1:0] ballot,
    input  logic [pvt_pkg::COUNT_W-1:0]  best_votes,
    output pvt_pkg::pvt_cmp_t            result
);

    logic                         match;
    logic [pvt_pkg::COUNT_W-1:0]  eff;

    // The entry that holds the ballot gains this vote before it is ranked.
    assign match = (entry_value == ballot);
    assign eff   = entry_votes + pvt_pkg::COUNT_W'(match);

    assign result.match     = match;
    assign result.eff_votes = eff;
    assign result.greater   = (eff > best_votes);
    assign result.equal     = (eff == best_votes);

endmodule

FILE: hdl/plurality_vote_tally_core.sv
// Top level of the plurality vote tally: handshakes, sequencer, session state.
// Depends on pvt_pkg, pvt_ram and pvt_cmp_unit.
//
//   Channel  Direction  Handshake            Contents
//   s_       in         s_tvalid/s_tready    tuser: cmd; tdata: node, ballot, known
//   m_       out        m_tvalid/m_tready    tdata: one result word per input word
//   cfg_     in         cfg_wr_en            min_votes, written without wait
//
// A clear word, an ignored vote or an overrun goes straight to the result.
// A counted vote first makes one pass over the candidate RAM, each entry a
// read state and a check state through the single compare unit, then takes
// an append state; an evaluation step settles the plurality when at least
// min_votes votes are in, before the result word goes out.
// Reset is synchronous and clears the session; the candidate RAM is tracked
// by a fill count and needs no clearing pass. A result that waits on m_tready
// holds the sequencer; one further input word is taken meanwhile.
module plurality_vote_tally_core #(
    parameter int MAX_NODES = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [pvt_pkg::COUNT_W-1:0]     cfg_wr_data,  // min_votes

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pvt_pkg::S_TDATA_W-1:0]   s_tdata,      // node, ballot, known_nodes
    input  logic                            s_tuser,      // cmd

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted, status, leader_value, tie, overrun, votes_cast
    output logic [pvt_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int ADDR_W  = $clog2(MAX_NODES);
    localparam int CT_W    = $clog2(MAX_NODES + 1);
    localparam int ENTRY_W = pvt_pkg::BALLOT_W + pvt_pkg::COUNT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    // Input word fields.
    logic                            in_cmd;
    logic [pvt_pkg::NODE_IDX_W-1:0]  in_node;
    logic [pvt_pkg::BALLOT_W-1:0]    in_ballot;
    logic [pvt_pkg::COUNT_W-1:0]     in_known;

    assign in_cmd    = s_tuser;
    assign in_node   = s_tdata[4:0];
    assign in_ballot = s_tdata[36:5];
    assign in_known  = s_tdata[42:37];

    // Registers.
    state_t                          state_reg, state_next;
    logic [pvt_pkg::COUNT_W-1:0]     min_votes_reg;
    logic [MAX_NODES-1:0]            node_valid_reg, node_valid_next;
    logic [pvt_pkg::BALLOT_W-1:0]    host_ballot_reg, host_ballot_next;
    logic [CT_W-1:0]                 cand_total_reg, cand_total_next;
    logic [pvt_pkg::COUNT_W-1:0]     vote_total_reg, vote_total_next;
    logic [pvt_pkg::BALLOT_W-1:0]    majority_reg, majority_next;
    logic                            tie_reg, tie_next;
    logic [pvt_pkg::BALLOT_W-1:0]    ballot_reg, ballot_next;
    logic                            accepted_reg, accepted_next;
    logic                            counted_reg, counted_next;
    logic                            overrun_reg, overrun_next;
    logic [ADDR_W-1:0]               scan_idx_reg, scan_idx_next;
    logic [pvt_pkg::COUNT_W-1:0]     best_reg, best_next;
    logic [pvt_pkg::BALLOT_W-1:0]    best_val_reg, best_val_next;
    logic                            tied_reg, tied_next;
    logic                            matched_reg, matched_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [pvt_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // RAM and compare unit signals.
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [ENTRY_W-1:0]              ram_wdata;
    logic [ENTRY_W-1:0]              ram_rdata;
    logic [pvt_pkg::BALLOT_W-1:0]    cmp_value;
    logic [pvt_pkg::COUNT_W-1:0]     cmp_votes;
    pvt_pkg::pvt_cmp_t               cmp;

    // Decode helpers for the accepted word.
    logic                            s_fire;
    logic                            node_in_range;
    logic [ADDR_W-1:0]               node_sel;
    logic                            eligible;
    logic                            overrun_hit;
    logic                            out_free;
    logic                            last_entry;
    logic                            evaluate_en;
    logic [pvt_pkg::STATUS_W-1:0]    status;

    assign s_tready      = (state_reg == ST_IDLE);
    assign s_fire        = s_tvalid && s_tready;
    assign node_in_range = (32'(in_node) < MAX_NODES);
    assign node_sel      = ADDR_W'(in_node);
    assign eligible      = (in_ballot != '0) && node_in_range && !node_valid_reg[node_sel];
    assign overrun_hit   = ({1'b0, vote_total_reg} + 7'd1) > {1'b0, in_known};
    assign out_free      = !m_tvalid_reg || m_tready;
    assign last_entry    = ((CT_W'(scan_idx_reg) + CT_W'(1)) == cand_total_reg);
    assign evaluate_en   = (vote_total_reg >= min_votes_reg);

    // Candidate store: value in the upper bits, vote count in the lower.
    pvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_cand_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rdata)
    );

    // The compare unit sees the RAM entry during the scan and a fresh
    // zero-vote entry holding the ballot when a candidate is appended.
    always_comb begin
        if (state_reg == ST_APPEND) begin
            cmp_value = ballot_reg;
            cmp_votes = '0;
        end else begin
            cmp_value = ram_rdata[ENTRY_W-1:pvt_pkg::COUNT_W];
            cmp_votes = ram_rdata[pvt_pkg::COUNT_W-1:0];
        end
    end

    pvt_cmp_unit u_cmp (
        .entry_value (cmp_value),
        .entry_votes (cmp_votes),
        .ballot      (ballot_reg),
        .best_votes  (best_reg),
        .result      (cmp)
    );

    // Status is derived from the session state as it stands at the result.
    always_comb begin
        if (vote_total_reg < min_votes_reg || tie_reg || majority_reg == '0) begin
            status = pvt_pkg::STATUS_NONE;
        end else if (node_valid_reg[0] && host_ballot_reg == majority_reg) begin
            status = pvt_pkg::STATUS_AGREE;
        end else begin
            status = pvt_pkg::STATUS_DISAGREE;
        end
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next       = state_reg;
        node_valid_next  = node_valid_reg;
        host_ballot_next = host_ballot_reg;
        cand_total_next  = cand_total_reg;
        vote_total_next  = vote_total_reg;
        majority_next    = majority_reg;
        tie_next         = tie_reg;
        ballot_next      = ballot_reg;
        accepted_next    = accepted_reg;
        overrun_next     = overrun_reg;
        scan_idx_next    = scan_idx_reg;
        best_next        = best_reg;
        best_val_next    = best_val_reg;
        tied_next        = tied_reg;
        matched_next     = matched_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_idx_reg;
        ram_wdata        = {cmp_value, cmp.eff_votes};

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ballot_next   = in_ballot;
                    accepted_next = 1'b0;
                    overrun_next  = 1'b0;
                    scan_idx_next = '0;
                    best_next     = '0;
                    best_val_next = '0;
                    tied_next     = 1'b0;
                    matched_next  = 1'b0;
                    state_next    = ST_DONE;
                    if (in_cmd == pvt_pkg::CMD_CLEAR || (eligible && overrun_hit)) begin
                        // Clear command or overrun: empty the session.
                        node_valid_next = '0;
                        cand_total_next = '0;
                        vote_total_next = '0;
                        majority_next   = '0;
                        tie_next        = 1'b0;
                        overrun_next    = (in_cmd == pvt_pkg::CMD_VOTE);
                    end else if (eligible) begin
                        // Counted vote: record the node, then scan candidates.
                        accepted_next             = 1'b1;
                        vote_total_next           = vote_total_reg + pvt_pkg::COUNT_W'(1);
                        node_valid_next[node_sel] = 1'b1;
                        if (in_node == '0) begin
                            host_ballot_next = in_ballot;
                        end
                        state_next = (cand_total_reg == '0) ? ST_APPEND : ST_READ;
                    end
                end
            end

            ST_READ: begin
                // Address is on the RAM; data arrives next cycle.
                state_next = ST_CHECK;
            end

            ST_CHECK: begin
                // Rank the entry; a matching entry is written back incremented.
                if (cmp.greater) begin
                    best_next     = cmp.eff_votes;
                    best_val_next = cmp_value;
                    tied_next     = 1'b0;
                end else if (cmp.equal) begin
                    tied_next = 1'b1;
                end
                if (cmp.match) begin
                    ram_we       = 1'b1;
                    matched_next = 1'b1;
                end
                if (last_entry) begin
                    state_next = ST_APPEND;
                end else begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                    state_next    = ST_READ;
                end
            end

            ST_APPEND: begin
                // A new value opens an entry with one vote, ranked last, while the store has room.
                if (!matched_reg && cand_total_reg < CT_W'(MAX_NODES)) begin
                    ram_we          = 1'b1;
                    ram_waddr       = cand_total_reg[ADDR_W-1:0];
                    cand_total_next = cand_total_reg + CT_W'(1);
                    if (cmp.greater) begin
                        best_next     = cmp.eff_votes;
                        best_val_next = cmp_value;
                        tied_next     = 1'b0;
                    end else if (cmp.equal) begin
                        tied_next = 1'b1;
                    end
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // Settle the plurality once if min_votes votes are in, then hand out the result word.
                if (accepted_reg && evaluate_en) begin
                    tie_next      = tied_reg;
                    majority_next = (tied_reg || best_reg == '0) ? '0 : best_val_reg;
                    accepted_next = 1'b0;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, vote_total_reg, overrun_reg, tie_reg,
                                     majority_reg, status, counted_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The accepted flag survives the evaluation step in a register of its own.
    always_comb begin
        counted_next = counted_reg;
        if (s_fire) begin
            counted_next = (in_cmd == pvt_pkg::CMD_VOTE) && eligible && !overrun_hit;
        end
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_votes_reg  <= pvt_pkg::MIN_VOTES_RST;
            node_valid_reg <= '0;
            cand_total_reg <= '0;
            vote_total_reg <= '0;
            majority_reg   <= '0;
            tie_reg        <= 1'b0;
            accepted_reg   <= 1'b0;
            counted_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_valid_reg <= node_valid_next;
            cand_total_reg <= cand_total_next;
            vote_total_reg <= vote_total_next;
            majority_reg   <= majority_next;
            tie_reg        <= tie_next;
            accepted_reg   <= accepted_next;
            counted_reg    <= counted_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                min_votes_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        host_ballot_reg <= host_ballot_next;
        ballot_reg      <= ballot_next;
        overrun_reg     <= overrun_next;
        scan_idx_reg    <= scan_idx_next;
        best_reg        <= best_next;
        best_val_reg    <= best_val_next;
        tied_reg        <= tied_next;
        matched_reg     <= matched_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
